### design/catlb_pkg.sv
// ----------------------------------------------------------------------------
// catlb_pkg
// Shared types and constants for the compacting associative translation table.
// ----------------------------------------------------------------------------
package catlb_pkg;

   localparam int PAGE_W  = 52;
   localparam int FLAG_W  = 12;
   localparam int ASID_W  = 16;
   localparam int CMD_W   = 3;
   localparam int COUNT_W = 7;

   localparam logic [CMD_W-1:0] CMD_LOOKUP      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MAP         = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNMAP       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PROTECT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH_ALL   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FLUSH_RANGE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_FLUSH_ASID  = 3'd6;
   // unused code, answered as done with the table untouched
   localparam logic [CMD_W-1:0] CMD_RESERVED    = 3'd7;

   localparam logic [FLAG_W-1:0] FLAG_MASK = 12'hFFF;

   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURRENT_ASID = 1'b0;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [PAGE_W-1:0] virt_page;
      logic [PAGE_W-1:0] phys_page;
      logic [FLAG_W-1:0] page_flags;
      logic [PAGE_W-1:0] range_end_page;
      logic [ASID_W-1:0] asid_match;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [PAGE_W-1:0] found_phys_page;
      logic [FLAG_W-1:0] found_flags;
      logic [COUNT_W-1:0] entries_used;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic scan;     // step the scan/compaction pointer
      logic finish;   // commit count and build result
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

### design/catlb_if.sv
// ----------------------------------------------------------------------------
// catlb_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface catlb_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### design/catlb_ctrl.sv
// ----------------------------------------------------------------------------
// catlb_ctrl
// Sequencer: accept a command, run the slot scan, hand the result out.
// ----------------------------------------------------------------------------
module catlb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  catlb_pkg::sts_type  sts,
   output catlb_pkg::ctl_type  ctl
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in   = state_ff;
      ctl.load   = 1'b0;
      ctl.scan   = 1'b0;
      ctl.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_DONE;
            end else begin
               ctl.scan = 1'b1;
            end
         end
         ST_DONE: begin
            ctl.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### design/catlb_dpath.sv
// ----------------------------------------------------------------------------
// catlb_dpath
// Entry memory with a read pointer and a write pointer; one slot per cycle is
// read, tested and, if kept, copied down to the write pointer.
// ----------------------------------------------------------------------------
module catlb_dpath #(
   parameter int ENTRIES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  catlb_pkg::ctl_type             ctl,
   output catlb_pkg::sts_type             sts,
   input  catlb_pkg::req_type             req,
   input  logic [catlb_pkg::ASID_W-1:0]   cur_asid,
   output catlb_pkg::rsp_type             rsp
);
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef struct packed {
      logic [catlb_pkg::PAGE_W-1:0] vtag;
      logic [catlb_pkg::PAGE_W-1:0] ppage;
      logic [catlb_pkg::FLAG_W-1:0] attr;
      logic [catlb_pkg::ASID_W-1:0] space;
   } entry_type;

   entry_type mem [ENTRIES];

   catlb_pkg::req_type  req_ff;
   catlb_pkg::rsp_type  rsp_ff, rsp_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    rd_ff, wr_ff;
   logic                pend_ff;
   entry_type           rd_ent_ff;
   logic                hit_ff, found_ff;
   logic [catlb_pkg::PAGE_W-1:0] fphys_ff;
   logic [catlb_pkg::FLAG_W-1:0] fflags_ff;

   logic      proc, issue, drop, matched, keep, wr_en;
   entry_type wr_ent;
   logic [IDX_W-1:0] wr_idx;
   logic [CNT_W-1:0] next_count;

   // a slot is tested the cycle after its read is issued
   assign proc    = ctl.scan && pend_ff;
   assign issue   = ctl.scan && (rd_ff != count_ff);
   assign matched = !found_ff && (rd_ent_ff.vtag == req_ff.virt_page);

   always_comb begin
      drop = 1'b0;
      case (req_ff.command) inside
         catlb_pkg::CMD_MAP, catlb_pkg::CMD_UNMAP: drop = matched;
         catlb_pkg::CMD_FLUSH_ALL:                 drop = 1'b1;
         catlb_pkg::CMD_FLUSH_RANGE:
            drop = (rd_ent_ff.vtag >= req_ff.virt_page) &&
                   (rd_ent_ff.vtag < req_ff.range_end_page);
         catlb_pkg::CMD_FLUSH_ASID:                drop = (rd_ent_ff.space == req_ff.asid_match);
         default:                                  drop = 1'b0;
      endcase
   end

   assign keep = !drop;
   assign sts.scan_done = (rd_ff == count_ff) && !pend_ff;

   // memory write: compaction copy during scan, protect update, map append at finish
   always_comb begin
      wr_en  = 1'b0;
      wr_idx = wr_ff[IDX_W-1:0];
      wr_ent = rd_ent_ff;
      if (proc) begin
         wr_en = keep;
         if (req_ff.command == catlb_pkg::CMD_PROTECT && matched) begin
            wr_ent.attr = req_ff.page_flags;
         end
      end else if (ctl.finish && req_ff.command == catlb_pkg::CMD_MAP) begin
         wr_en        = 1'b1;
         wr_idx       = (wr_ff == CNT_W'(ENTRIES)) ? '0 : wr_ff[IDX_W-1:0];
         wr_ent.vtag  = req_ff.virt_page;
         wr_ent.ppage = req_ff.phys_page;
         wr_ent.attr  = req_ff.page_flags;
         wr_ent.space = cur_asid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ent_ff <= mem[rd_ff[IDX_W-1:0]];
      end
   end

   assign next_count = (req_ff.command == catlb_pkg::CMD_MAP && wr_ff != CNT_W'(ENTRIES)) ?
                       wr_ff + CNT_W'(1) : wr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.finish) begin
         count_ff <= next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff   <= req;
         rd_ff    <= '0;
         wr_ff    <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
         fphys_ff <= '0;
         fflags_ff <= '0;
      end else if (ctl.scan) begin
         pend_ff <= issue;
         if (issue) begin
            rd_ff <= rd_ff + CNT_W'(1);
         end
         if (proc && keep) begin
            wr_ff <= wr_ff + CNT_W'(1);
         end
         if (proc && matched) begin
            found_ff  <= 1'b1;
            hit_ff    <= 1'b1;
            fphys_ff  <= rd_ent_ff.ppage;
            fflags_ff <= (req_ff.command == catlb_pkg::CMD_PROTECT) ?
                         req_ff.page_flags : rd_ent_ff.attr;
         end
      end
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.entries_used = catlb_pkg::COUNT_W'(next_count);
      case (req_ff.command) inside
         catlb_pkg::CMD_LOOKUP, catlb_pkg::CMD_PROTECT: begin
            rsp_in.status          = !hit_ff;
            rsp_in.found_phys_page = fphys_ff;
            rsp_in.found_flags     = fflags_ff & catlb_pkg::FLAG_MASK;
         end
         catlb_pkg::CMD_UNMAP: rsp_in.status = !hit_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;
endmodule

### design/compacting_assoc_tlb_unit.sv
// ----------------------------------------------------------------------------
// compacting_assoc_tlb_unit
// Fully associative translation table with address space tags, kept packed.
//
//   channel | direction | handshake      | payload
//   req     | in        | valid/ready    | command, pages, flags, range, asid
//   rsp     | out       | valid/ready    | status, phys page, flags, count
//   csr     | in        | APB write/read | current_asid
//
// From accept to the next accept, with the result taken at once, an item passes
// through: accept, a scan that reads one slot a cycle from the registered entry
// memory and tests it the cycle after (on an empty table it reads no slot), a
// step to see the scan end, a commit, and the output.
// Reset is synchronous and clears the count; the entry memory is not cleared.
// The next item is accepted after the result has been taken.
// ----------------------------------------------------------------------------
module compacting_assoc_tlb_unit #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   catlb_if.sink                                 req,
   catlb_if.source                               rsp,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [catlb_pkg::CSR_ADDR_W+1:0]      csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   catlb_pkg::ctl_type ctl;
   catlb_pkg::sts_type sts;
   catlb_pkg::rsp_type rsp_data;
   logic [catlb_pkg::ASID_W-1:0] asid_ff;
   logic reg_hit;

   assign reg_hit    = (csr_paddr[catlb_pkg::CSR_ADDR_W+1:2] == catlb_pkg::CSR_CURRENT_ASID)
                       && (csr_paddr[1:0] == 2'b00);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? {16'd0, asid_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         asid_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         asid_ff <= csr_pwdata[catlb_pkg::ASID_W-1:0];
      end
   end

   catlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   catlb_dpath #(.ENTRIES(SLOT_COUNT)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sts      (sts),
      .req      (req.data),
      .cur_asid (asid_ff),
      .rsp      (rsp_data)
   );

   assign rsp.data = rsp_data;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accept while result pending");
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !rsp.valid) else $error("result too early");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((SLOT_COUNT > 127) || (rsp_data.entries_used <= 7'(SLOT_COUNT))))
      else $error("count over depth");
endmodule
